FILE: sv/lrsr_pkg.sv
// ----------------------------------------------------------------------------
// lrsr_pkg
// Shared widths, operation, action and event codes, and the result record
// of the LR shift-reduce parse engine.
// ----------------------------------------------------------------------------
package lrsr_pkg;

	// Payload field widths.
	localparam int OP_W    = 3;
	localparam int STATE_W = 6;
	localparam int SYM_W   = 5;
	localparam int NT_W    = 4;
	localparam int KIND_W  = 2;
	localparam int RULE_W  = 6;
	localparam int RLEN_W  = 4;
	localparam int EV_W    = 3;

	// Operation codes of an input item.
	localparam logic [OP_W-1:0] OP_LOAD_ACTION = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_GOTO   = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_RULE   = 3'd2;
	localparam logic [OP_W-1:0] OP_TOKEN       = 3'd3;
	localparam logic [OP_W-1:0] OP_START       = 3'd4;

	// Action table entry kinds.
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd3;

	// Result event codes.
	localparam logic [EV_W-1:0] EV_REDUCE = 3'd0;
	localparam logic [EV_W-1:0] EV_SHIFT  = 3'd1;
	localparam logic [EV_W-1:0] EV_ACCEPT = 3'd2;
	localparam logic [EV_W-1:0] EV_SYNTAX = 3'd3;
	localparam logic [EV_W-1:0] EV_FAULT  = 3'd4;

	// Reductions allowed on one token before a fault.
	localparam int MAX_REDUCTIONS = 63;
	localparam int RED_W          = 6;

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [RULE_W-1:0]  rule;
		logic [STATE_W-1:0] state;
		logic               last;
	} res_t;

endpackage

FILE: sv/lrsr_ram.sv
// ----------------------------------------------------------------------------
// lrsr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module lrsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lr_shift_reduce_parser.sv
// A load or start item is handled in the idle step itself. A token's closing
// result is registered after a stack read and an action read, and each
// reduction before it adds a rule, stack, goto and action read in turn through
// the RAM ports; each reduce result is registered in the goto step of the
// reduction that a decode step starts. A result held by a low out_ready
// stalls the sequencer. The engine takes one item at a time; ready stays
// low until the token's last result is in the output register. After reset
// a clearing pass writes every action entry to error.
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser
// Table-driven LR parse engine: action, goto and rule tables plus a state
// stack in RAM, walked by a small sequencer that issues one memory read per step.
// ----------------------------------------------------------------------------
module lr_shift_reduce_parser #(
	parameter int STATES      = 64,
	parameter int TERMINALS   = 32,
	parameter int NONTERMS    = 16,
	parameter int RULES       = 64,
	parameter int STACK_DEPTH = 64,
	parameter int MAX_BODY    = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lrsr_pkg::OP_W-1:0]       operation,
	input  logic [lrsr_pkg::STATE_W-1:0]    state_index,
	input  logic [lrsr_pkg::SYM_W-1:0]      symbol,
	input  logic [lrsr_pkg::NT_W-1:0]       nonterminal,
	input  logic [lrsr_pkg::KIND_W-1:0]     action_kind,
	input  logic [lrsr_pkg::STATE_W-1:0]    action_target,
	input  logic [lrsr_pkg::STATE_W-1:0]    goto_state,
	input  logic [lrsr_pkg::RULE_W-1:0]     rule_number,
	input  logic [lrsr_pkg::RLEN_W-1:0]     rule_length,
	input  logic [lrsr_pkg::NT_W-1:0]       rule_head,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lrsr_pkg::EV_W-1:0]       event_res,
	output logic [lrsr_pkg::RULE_W-1:0]     rule_used,
	output logic [lrsr_pkg::STATE_W-1:0]    new_state,
	output logic                            last
);

	import lrsr_pkg::*;

	// Table extents are capped by what the fixed field widths can address.
	localparam int AS = (STATES < (1 << STATE_W)) ? STATES : (1 << STATE_W);
	localparam int AT = (TERMINALS < (1 << SYM_W)) ? TERMINALS : (1 << SYM_W);
	localparam int GN = (NONTERMS < (1 << NT_W)) ? NONTERMS : (1 << NT_W);
	localparam int RR = (RULES < (1 << RULE_W)) ? RULES : (1 << RULE_W);
	localparam int ACT_DEPTH  = AS * AT;
	localparam int GOTO_DEPTH = AS * GN;
	localparam int AA_W = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int GA_W = (GOTO_DEPTH > 1) ? $clog2(GOTO_DEPTH) : 1;
	localparam int RA_W = (RR > 1) ? $clog2(RR) : 1;
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int ACT_W = KIND_W + STATE_W;
	localparam int RENT_W = RLEN_W + NT_W;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_ACT, S_DEC, S_RULE, S_UNDER, S_GOTO
	} state_t;

	state_t               state_q;
	logic [AA_W-1:0]      clr_q;
	logic [SP_W-1:0]      sp_q;
	logic [RED_W-1:0]     red_q;
	logic [SYM_W-1:0]     sym_q;
	logic [STATE_W-1:0]   top_q;
	logic                 act_ok_q;
	logic [RULE_W-1:0]    rule_q;
	logic [RLEN_W-1:0]    len_q;
	logic [NT_W-1:0]      head_q;
	logic                 out_valid_q;
	res_t                 res_q;

	logic                 act_we, act_re;
	logic [AA_W-1:0]      act_waddr, act_raddr;
	logic [ACT_W-1:0]     act_wdata, act_rdata;
	logic                 goto_we, goto_re;
	logic [GA_W-1:0]      goto_waddr, goto_raddr;
	logic [STATE_W-1:0]   goto_rdata;
	logic                 rule_we, rule_re;
	logic [RA_W-1:0]      rule_waddr, rule_raddr;
	logic [RENT_W-1:0]    rule_rdata;
	logic                 stk_we, stk_re;
	logic [SA_W-1:0]      stk_waddr, stk_raddr;
	logic [STATE_W-1:0]   stk_wdata, stk_rdata;

	logic                 in_fire;
	logic                 out_free;
	logic                 res_load;
	logic                 red_go;
	logic [KIND_W-1:0]    kind_eff;
	logic [STATE_W-1:0]   target;
	logic [RLEN_W-1:0]    r_len;
	logic [NT_W-1:0]      r_head;
	logic [SP_W-1:0]      sp_m1;
	logic [SP_W-1:0]      under_ptr;
	logic [SP_W-1:0]      pop_base;
	logic                 dest_ok;

	function automatic logic [AA_W-1:0] act_addr(input logic [STATE_W-1:0] st,
			input logic [SYM_W-1:0] sy);
		act_addr = AA_W'(int'(st) * AT + int'(sy));
	endfunction

	function automatic logic [GA_W-1:0] goto_addr(input logic [STATE_W-1:0] st,
			input logic [NT_W-1:0] nt);
		goto_addr = GA_W'(int'(st) * GN + int'(nt));
	endfunction

	lrsr_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_action (
		.clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
		.re(act_re), .raddr(act_raddr), .rdata(act_rdata)
	);

	lrsr_ram #(.WIDTH(STATE_W), .DEPTH(GOTO_DEPTH)) u_goto (
		.clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_state),
		.re(goto_re), .raddr(goto_raddr), .rdata(goto_rdata)
	);

	lrsr_ram #(.WIDTH(RENT_W), .DEPTH(RR)) u_rule (
		.clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata({rule_length, rule_head}),
		.re(rule_re), .raddr(rule_raddr), .rdata(rule_rdata)
	);

	lrsr_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign kind_eff  = act_ok_q ? act_rdata[ACT_W-1 -: KIND_W] : KIND_ERROR;
	assign target    = act_rdata[STATE_W-1:0];
	assign r_len     = rule_rdata[RENT_W-1 -: RLEN_W];
	assign r_head    = rule_rdata[NT_W-1:0];
	assign sp_m1     = sp_q - 1'b1;
	assign under_ptr = sp_q - SP_W'(r_len) - 1'b1;
	assign pop_base  = sp_q - SP_W'(len_q);
	assign dest_ok   = (32'(goto_rdata) < STATES) && (32'(sym_q) < TERMINALS);
	assign red_go    = (kind_eff == KIND_REDUCE) && (32'(red_q) < MAX_REDUCTIONS) &&
		(32'(target) < RULES);

	// Memory port control for each sequencer step.
	always_comb begin
		act_we     = 1'b0;
		act_re     = 1'b0;
		act_waddr  = act_addr(state_index, symbol);
		act_wdata  = {action_kind, action_target};
		act_raddr  = act_addr(stk_rdata, sym_q);
		goto_we    = 1'b0;
		goto_re    = 1'b0;
		goto_waddr = goto_addr(state_index, nonterminal);
		goto_raddr = goto_addr(stk_rdata, head_q);
		rule_we    = 1'b0;
		rule_re    = 1'b0;
		rule_waddr = RA_W'(rule_number);
		rule_raddr = RA_W'(target);
		stk_we     = 1'b0;
		stk_re     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = '0;
		stk_raddr  = sp_m1[SA_W-1:0];
		res_load   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				act_we    = 1'b1;
				act_waddr = clr_q;
				act_wdata = '0;
				stk_we    = 1'b1;
			end
			S_IDLE: begin
				if (in_fire) begin
					case (operation)
						OP_LOAD_ACTION: begin
							act_we = (32'(state_index) < STATES) && (32'(symbol) < TERMINALS);
						end
						OP_LOAD_GOTO: begin
							goto_we = (32'(state_index) < STATES) && (32'(nonterminal) < NONTERMS);
						end
						OP_LOAD_RULE: begin
							rule_we = (32'(rule_number) < RULES) && (32'(rule_length) <= MAX_BODY);
						end
						OP_TOKEN: begin
							stk_re = 1'b1;
						end
						OP_START: begin
							stk_we = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ACT: begin
				act_re = 1'b1;
			end
			S_DEC: begin
				if (out_free) begin
					if (kind_eff == KIND_SHIFT && 32'(sp_q) < STACK_DEPTH) begin
						stk_we    = 1'b1;
						stk_waddr = sp_q[SA_W-1:0];
						stk_wdata = target;
					end
					if (red_go) begin
						rule_re = 1'b1;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			S_RULE: begin
				stk_raddr = under_ptr[SA_W-1:0];
				if (out_free) begin
					if (32'(r_len) < 32'(sp_q)) begin
						stk_re = 1'b1;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			S_UNDER: begin
				if (out_free) begin
					if (32'(stk_rdata) < STATES && 32'(head_q) < NONTERMS &&
							32'(pop_base) < STACK_DEPTH) begin
						goto_re = 1'b1;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			S_GOTO: begin
				// Push the goto state and look up the action for it at once.
				act_raddr = act_addr(goto_rdata, sym_q);
				stk_waddr = pop_base[SA_W-1:0];
				stk_wdata = goto_rdata;
				if (out_free) begin
					stk_we   = 1'b1;
					act_re   = 1'b1;
					res_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sp_q        <= SP_W'(1);
			red_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !out_ready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == ACT_DEPTH - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (operation)
							OP_TOKEN: begin
								sym_q   <= symbol;
								red_q   <= '0;
								state_q <= S_ACT;
							end
							OP_START: begin
								sp_q <= SP_W'(1);
							end
							default: begin
							end
						endcase
					end
				end
				S_ACT: begin
					top_q    <= stk_rdata;
					act_ok_q <= (32'(stk_rdata) < STATES) && (32'(sym_q) < TERMINALS);
					state_q  <= S_DEC;
				end
				S_DEC: begin
					if (out_free) begin
						if (red_go) begin
							// No result yet; the reduction goes on.
							rule_q  <= target;
							state_q <= S_RULE;
						end else begin
							state_q <= S_IDLE;
							case (kind_eff)
								KIND_SHIFT: begin
									if (32'(sp_q) >= STACK_DEPTH) begin
										res_q <= '{EV_FAULT, '0, top_q, 1'b1};
									end else begin
										sp_q  <= sp_q + 1'b1;
										res_q <= '{EV_SHIFT, '0, target, 1'b1};
									end
								end
								KIND_ACCEPT: begin
									res_q <= '{EV_ACCEPT, '0, top_q, 1'b1};
								end
								KIND_REDUCE: begin
									if (32'(red_q) >= MAX_REDUCTIONS) begin
										res_q <= '{EV_FAULT, '0, top_q, 1'b1};
									end else begin
										res_q <= '{EV_SYNTAX, '0, top_q, 1'b1};
									end
								end
								default: begin
									res_q <= '{EV_SYNTAX, '0, top_q, 1'b1};
								end
							endcase
						end
					end
				end
				S_RULE: begin
					if (out_free) begin
						if (32'(r_len) >= 32'(sp_q)) begin
							res_q   <= '{EV_FAULT, '0, top_q, 1'b1};
							state_q <= S_IDLE;
						end else begin
							len_q   <= r_len;
							head_q  <= r_head;
							state_q <= S_UNDER;
						end
					end
				end
				S_UNDER: begin
					if (out_free) begin
						if (32'(stk_rdata) >= STATES || 32'(head_q) >= NONTERMS) begin
							res_q   <= '{EV_SYNTAX, '0, top_q, 1'b1};
							state_q <= S_IDLE;
						end else if (32'(pop_base) >= STACK_DEPTH) begin
							res_q   <= '{EV_FAULT, '0, top_q, 1'b1};
							state_q <= S_IDLE;
						end else begin
							state_q <= S_GOTO;
						end
					end
				end
				S_GOTO: begin
					if (out_free) begin
						sp_q     <= pop_base + 1'b1;
						red_q    <= red_q + 1'b1;
						top_q    <= goto_rdata;
						act_ok_q <= dest_ok;
						res_q    <= '{EV_REDUCE, rule_q, goto_rdata, 1'b0};
						state_q  <= S_DEC;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = res_q.ev;
	assign rule_used = res_q.rule;
	assign new_state = res_q.state;
	assign last      = res_q.last;

	// The stack always holds at least the bottom state and never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q != '0 && 32'(sp_q) <= STACK_DEPTH)
		else $error("stack pointer out of range");

	// Reductions are never the closing result of a token.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev == EV_REDUCE |-> !res_q.last)
		else $error("reduce result marked last");

	// Every other event ends the token.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev != EV_REDUCE |-> res_q.last)
		else $error("terminal result not marked last");

	// A reduction leaves the goto state on top of a stack that shrank by the body.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GOTO && out_free |=> sp_q == $past(pop_base) + 1'b1)
		else $error("stack pointer wrong after reduction");

endmodule
